FILE: rtl/nfda_pkg.sv
// Shared types and constants of the next-fit descriptor allocator.
// No dependencies; used by the channel interfaces and the top level.
package nfda_pkg;

    localparam int SLOTS_DEF = 64;

    localparam int FUNC_W    = 3;
    localparam int FD_W      = 11;
    localparam int HANDLE_W  = 32;
    localparam int BASE_W    = 10;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 7;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] REG_FD_BASE = APB_AW'(0);

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC  = 3'd0,
        FN_FREE   = 3'd1,
        FN_LOOKUP = 3'd2,
        FN_FIND   = 3'd3,
        FN_CLEAR  = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [FD_W-1:0]      fd_out;
        logic [HANDLE_W-1:0]  handle_out;
        logic                 released;
        logic [CNT_OUT_W-1:0] open_count;
    } t_res;

endpackage

FILE: rtl/nfda_req_if.sv
// Request channel of the descriptor allocator: valid/ready plus request fields.
// Depends on nfda_pkg.
interface nfda_req_if import nfda_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [FD_W-1:0]     fd;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, func, fd, handle, input ready);
    modport sink   (input valid, func, fd, handle, output ready);
endinterface

FILE: rtl/nfda_rsp_if.sv
// Response channel of the descriptor allocator: valid/ready plus result fields.
// Depends on nfda_pkg.
interface nfda_rsp_if import nfda_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [FD_W-1:0]      fd_out;
    logic [HANDLE_W-1:0]  handle_out;
    logic                 released;
    logic [CNT_OUT_W-1:0] open_count;

    modport source (output valid, status, fd_out, handle_out, released, open_count,
                    input ready);
    modport sink   (input valid, status, fd_out, handle_out, released, open_count,
                    output ready);
endinterface

FILE: rtl/next_fit_descriptor_allocator_unit.sv
// Next-fit descriptor allocator: slot table in one synchronous memory, scan sequencer.
// Depends on nfda_pkg, nfda_req_if and nfda_rsp_if.
//
//   channel  | direction | handshake          | payload
//   i_req    | in        | valid/ready        | func, fd, handle
//   o_rsp    | out       | valid/ready        | status, fd_out, handle_out, released, open_count
//   apb      | in        | psel/penable/pready| paddr, pwdata, prdata (fd_base at 0)
//
// Free and lookup read the addressed slot, then respond; alloc scans from the
// rotating pointer to the first free slot; find scans the table from slot 0. Both walk
// the table one memory read per cycle. Clear sweeps every slot of the table.
// After reset a sweep clears the used bits before the first request is accepted.
// A response waiting on o_rsp holds the next result, not the next request.
module next_fit_descriptor_allocator_unit
    import nfda_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nfda_req_if.sink          i_req,
    nfda_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = HANDLE_W + 1;
    localparam logic [SW-1:0] LAST     = SW'(SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

    typedef enum logic [4:0] {
        S_INIT = 5'b00001,
        S_IDLE = 5'b00010,
        S_READ = 5'b00100,
        S_SCAN = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [BASE_W-1:0]   r_fd_base;
    logic [SW-1:0]       r_next, n_next;
    logic [CW-1:0]       r_used, n_used;
    logic [SW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_chk_vld, n_chk_vld;
    logic                r_clr_op, n_clr_op;
    logic                r_out_vld, n_out_vld;
    logic [SW-1:0]       r_chk, n_chk;
    logic [SW-1:0]       r_slot, n_slot;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [HANDLE_W-1:0] r_handle, n_handle;
    t_res                r_res, n_res;
    t_res                r_out, n_out;

    logic [MW-1:0]       r_mem [SLOTS];
    logic [MW-1:0]       r_rd_data;
    logic [SW-1:0]       rd_addr;
    logic                wr_en;
    logic [SW-1:0]       wr_addr;
    logic [MW-1:0]       wr_data;

    logic                in_fire;
    logic [FD_W:0]       fd_diff;
    logic                fd_ok;
    logic [SW-1:0]       fd_slot;
    logic                rd_used;
    logic [HANDLE_W-1:0] rd_handle;
    logic                hit;
    logic [SW-1:0]       ptr_inc;
    logic [SW-1:0]       chk_inc;
    logic                cfg_wr;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && (r_state == S_IDLE);

    assign fd_diff = {1'b0, i_req.fd} - (FD_W + 1)'(r_fd_base);
    assign fd_ok   = !fd_diff[FD_W] && (fd_diff < (FD_W + 1)'(SLOTS));
    assign fd_slot = fd_diff[SW-1:0];

    assign rd_used   = r_rd_data[MW-1];
    assign rd_handle = r_rd_data[HANDLE_W-1:0];
    assign ptr_inc   = (r_ptr == LAST) ? '0 : r_ptr + SW'(1);
    assign chk_inc   = (r_chk == LAST) ? '0 : r_chk + SW'(1);
    assign hit       = (r_func == FN_ALLOC) ? !rd_used
                                            : (rd_used && (rd_handle == r_handle));

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_FD_BASE[APB_AW-1:2])
                  ? APB_DW'(r_fd_base) : '0;

    always_comb begin
        n_state   = r_state;
        n_next    = r_next;
        n_used    = r_used;
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_chk_vld = r_chk_vld;
        n_clr_op  = r_clr_op;
        n_chk     = r_chk;
        n_slot    = r_slot;
        n_func    = r_func;
        n_handle  = r_handle;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        rd_addr   = r_ptr;
        wr_en     = 1'b0;
        wr_addr   = r_ptr;
        wr_data   = '0;

        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                wr_en = 1'b1;
                n_ptr = ptr_inc;
                if (r_ptr == LAST) begin
                    if (r_clr_op) begin
                        n_clr_op   = 1'b0;
                        n_next     = '0;
                        n_used     = '0;
                        n_res      = '0;
                        n_res.status = ST_OK;
                        n_state    = S_RESP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_func           = i_req.func;
                    n_handle         = i_req.handle;
                    n_res            = '0;
                    n_res.status     = ST_BAD;
                    n_res.open_count = CNT_OUT_W'(r_used);
                    n_state          = S_RESP;
                    case (t_func'(i_req.func))
                        FN_ALLOC: begin
                            if (i_req.handle != '0) begin
                                if (r_used == FULL_CNT) begin
                                    n_res.status = ST_FULL;
                                end else begin
                                    n_ptr     = r_next;
                                    n_cnt     = '0;
                                    n_chk_vld = 1'b0;
                                    n_state   = S_SCAN;
                                end
                            end
                        end
                        FN_FREE, FN_LOOKUP: begin
                            if (fd_ok) begin
                                rd_addr = fd_slot;
                                n_slot  = fd_slot;
                                n_state = S_READ;
                            end
                        end
                        FN_FIND: begin
                            if (i_req.handle != '0) begin
                                n_ptr     = '0;
                                n_cnt     = '0;
                                n_chk_vld = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        FN_CLEAR: begin
                            n_clr_op = 1'b1;
                            n_ptr    = '0;
                            n_state  = S_INIT;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (rd_used) begin
                    n_res.status     = ST_OK;
                    n_res.handle_out = rd_handle;
                    if (r_func == FN_FREE) begin
                        wr_en            = 1'b1;
                        wr_addr          = r_slot;
                        n_res.released   = 1'b1;
                        n_used           = r_used - CW'(1);
                        n_res.open_count = CNT_OUT_W'(r_used - CW'(1));
                    end
                end
                n_state = S_RESP;
            end
            S_SCAN: begin
                if (r_cnt != FULL_CNT) begin
                    n_ptr     = ptr_inc;
                    n_cnt     = r_cnt + CW'(1);
                    n_chk     = r_ptr;
                    n_chk_vld = 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld) begin
                    if (hit) begin
                        n_res.status = ST_OK;
                        n_res.fd_out = FD_W'(r_chk) + FD_W'(r_fd_base);
                        if (r_func == FN_ALLOC) begin
                            wr_en            = 1'b1;
                            wr_addr          = r_chk;
                            wr_data          = {1'b1, r_handle};
                            n_used           = r_used + CW'(1);
                            n_res.open_count = CNT_OUT_W'(r_used + CW'(1));
                            n_next           = chk_inc;
                        end
                        n_state = S_RESP;
                    end else if (r_cnt == FULL_CNT) begin
                        n_state = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_fd_base <= '0;
            r_next    <= '0;
            r_used    <= '0;
            r_ptr     <= '0;
            r_cnt     <= '0;
            r_chk_vld <= 1'b0;
            r_clr_op  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_next    <= n_next;
            r_used    <= n_used;
            r_ptr     <= n_ptr;
            r_cnt     <= n_cnt;
            r_chk_vld <= n_chk_vld;
            r_clr_op  <= n_clr_op;
            r_out_vld <= n_out_vld;
            if (cfg_wr && (paddr[APB_AW-1:2] == REG_FD_BASE[APB_AW-1:2])) begin
                r_fd_base <= pwdata[BASE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk    <= n_chk;
        r_slot   <= n_slot;
        r_func   <= n_func;
        r_handle <= n_handle;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.fd_out     = r_out.fd_out;
    assign o_rsp.handle_out = r_out.handle_out;
    assign o_rsp.released   = r_out.released;
    assign o_rsp.open_count = r_out.open_count;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the next-fit descriptor allocator: directed requests, then random phases.
// Depends on nfda_pkg, nfda_req_if, nfda_rsp_if and next_fit_descriptor_allocator_unit.
module tb_top;
    import nfda_pkg::*;

    localparam int SLOTS           = SLOTS_DEF;
    localparam int SLOT_W          = $clog2(SLOTS_DEF);
    localparam int PHASES          = 5;
    localparam int PHASE_ITEMS     = 240;
    localparam int IDLE_PCT        = 21;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 1_000_000;

    localparam logic [FUNC_W-1:0] FN_BAD_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_BAD_HI = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0]   op;
        logic [FD_W-1:0]     fd;
        logic [HANDLE_W-1:0] h;
        bit                  typed;
        t_res                res;
    } t_directed_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    nfda_req_if req_if ();
    nfda_rsp_if rsp_if ();

    next_fit_descriptor_allocator_unit #(.SLOTS(SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bit                   slot_busy [SLOTS];
    logic [HANDLE_W-1:0]  slot_obj  [SLOTS];
    logic [SLOT_W-1:0]    rover;
    logic [CNT_OUT_W-1:0] open_total;
    logic [BASE_W-1:0]    desc_base;
    logic [HANDLE_W-1:0]  handle_pool [8];

    t_res          pending_results [$];
    t_directed_row directed_rows [$];

    int mismatch_total;
    int cycle_count;
    bit steady_run;
    int hold_off_asked;
    int hold_off_served;
    int hold_off_left;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_res next_fit_result(input logic [FUNC_W-1:0] op,
                                             input logic [FD_W-1:0] fd,
                                             input logic [HANDLE_W-1:0] h);
        t_res              r;
        logic [SLOT_W-1:0] s;
        int                rel;
        r        = '0;
        r.status = ST_BAD;
        rel      = int'(fd) - int'(desc_base);
        case (op)
            FN_ALLOC: begin
                if (h != '0) begin
                    r.status = ST_FULL;
                    for (int i = 0; i < SLOTS; i++) begin
                        s = rover + SLOT_W'(i);
                        if (!slot_busy[s]) begin
                            slot_busy[s] = 1'b1;
                            slot_obj[s]  = h;
                            open_total++;
                            rover    = s + SLOT_W'(1);
                            r.fd_out = FD_W'(s) + FD_W'(desc_base);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            FN_FREE: begin
                if (rel >= 0 && rel < SLOTS && slot_busy[rel]) begin
                    r.handle_out   = slot_obj[rel];
                    r.released     = 1'b1;
                    slot_busy[rel] = 1'b0;
                    open_total--;
                    r.status = ST_OK;
                end
            end
            FN_LOOKUP: begin
                if (rel >= 0 && rel < SLOTS && slot_busy[rel]) begin
                    r.handle_out = slot_obj[rel];
                    r.status     = ST_OK;
                end
            end
            FN_FIND: begin
                if (h != '0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_busy[i] && slot_obj[i] == h) begin
                            r.fd_out = FD_W'(i) + FD_W'(desc_base);
                            r.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            FN_CLEAR: begin
                foreach (slot_busy[i]) slot_busy[i] = 1'b0;
                rover      = '0;
                open_total = '0;
                r.status   = ST_OK;
            end
            default: ;
        endcase
        r.open_count = open_total;
        return r;
    endfunction

    function automatic t_res mk_res(input t_status st, input int fd,
                                    input logic [HANDLE_W-1:0] h, input bit rel, input int cnt);
        t_res r;
        r.status     = st;
        r.fd_out     = FD_W'(fd);
        r.handle_out = h;
        r.released   = rel;
        r.open_count = CNT_OUT_W'(cnt);
        return r;
    endfunction

    function automatic void directed_req(input logic [FUNC_W-1:0] op, input int fd,
                                         input logic [HANDLE_W-1:0] h, input bit typed,
                                         input t_res res);
        t_directed_row row;
        row.op    = op;
        row.fd    = FD_W'(fd);
        row.h     = h;
        row.typed = typed;
        row.res   = res;
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_used_slot();
        int start;
        int s;
        start = $urandom_range(SLOTS - 1);
        for (int i = 0; i < SLOTS; i++) begin
            s = (start + i) % SLOTS;
            if (slot_busy[s]) return s;
        end
        return -1;
    endfunction

    function automatic logic [FD_W-1:0] pick_fd();
        int roll;
        int s;
        roll = $urandom_range(99);
        s    = pick_used_slot();
        if (roll < 70 && s >= 0) return FD_W'(s) + FD_W'(desc_base);
        if (roll < 80) begin
            if ($urandom_range(1) == 0) return FD_W'(desc_base) - FD_W'(1);
            return FD_W'(desc_base) + FD_W'(SLOTS);
        end
        if (roll < 90) return FD_W'(desc_base) + FD_W'($urandom_range(SLOTS - 1));
        return FD_W'($urandom_range((1 << FD_W) - 1));
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 40) return handle_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [FD_W-1:0] fd,
                                input logic [HANDLE_W-1:0] h, input bit typed,
                                input t_res typed_res);
        int   gap;
        t_res predicted;
        gap = 0;
        if (!steady_run) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.func   <= op;
        req_if.fd     <= fd;
        req_if.handle <= h;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = next_fit_result(op, fd, h);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic random_request();
        int                  roll;
        int                  s;
        logic [FUNC_W-1:0]   op;
        logic [FD_W-1:0]     fd;
        logic [HANDLE_W-1:0] h;
        roll = $urandom_range(99);
        fd   = FD_W'($urandom);
        h    = $urandom;
        if (roll < 40) begin
            op = FN_ALLOC;
            h  = pick_handle();
        end else if (roll < 60) begin
            op = FN_FREE;
            fd = pick_fd();
        end else if (roll < 73) begin
            op = FN_LOOKUP;
            fd = pick_fd();
        end else if (roll < 90) begin
            op = FN_FIND;
            s  = pick_used_slot();
            h  = ($urandom_range(99) < 55 && s >= 0) ? slot_obj[s] : pick_handle();
        end else if (roll < 91) begin
            op = FN_CLEAR;
        end else if (roll < 94) begin
            op = FUNC_W'($urandom_range(FN_BAD_HI, FN_BAD_LO));
        end else begin
            op = ($urandom_range(1) == 0) ? FN_FREE : FN_LOOKUP;
        end
        send_request(op, fd, h, 1'b0, t_res'(0));
    endtask

    task automatic wait_for_results();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_fd_base(input logic [BASE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_FD_BASE;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        desc_base = value;
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== APB_DW'(value)) begin
            $display("%0t: fd_base readback mismatch, expected %0d, got %0d",
                     $time, value, prdata);
            mismatch_total++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_off_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_left--;
        end else if (hold_off_served != hold_off_asked) begin
            hold_off_served++;
            hold_off_left = HOLD_OFF_CYCLES;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : rsp_check
        t_res want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response, expected none, got status %0d fd %0d",
                         $time, rsp_if.status, rsp_if.fd_out);
                mismatch_total++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, rsp_if.status);
                    mismatch_total++;
                end
                if (rsp_if.fd_out !== want.fd_out) begin
                    $display("%0t: fd_out mismatch, expected %0d, got %0d",
                             $time, want.fd_out, rsp_if.fd_out);
                    mismatch_total++;
                end
                if (rsp_if.handle_out !== want.handle_out) begin
                    $display("%0t: handle_out mismatch, expected %h, got %h",
                             $time, want.handle_out, rsp_if.handle_out);
                    mismatch_total++;
                end
                if (rsp_if.released !== want.released) begin
                    $display("%0t: released mismatch, expected %0d, got %0d",
                             $time, want.released, rsp_if.released);
                    mismatch_total++;
                end
                if (rsp_if.open_count !== want.open_count) begin
                    $display("%0t: open_count mismatch, expected %0d, got %0d",
                             $time, want.open_count, rsp_if.open_count);
                    mismatch_total++;
                end
            end
        end
    end

    initial begin
        logic [BASE_W-1:0]   phase_bases [PHASES];
        logic [HANDLE_W-1:0] h;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.func   = FN_ALLOC;
        req_if.fd     = '0;
        req_if.handle = '0;
        rsp_if.ready  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = REG_FD_BASE;
        pwdata        = '0;
        foreach (slot_busy[i]) begin
            slot_busy[i] = 1'b0;
            slot_obj[i]  = '0;
        end
        rover           = '0;
        open_total      = '0;
        desc_base       = '0;
        mismatch_total  = 0;
        cycle_count     = 0;
        steady_run      = 1'b0;
        hold_off_asked  = 0;
        hold_off_served = 0;
        hold_off_left   = 0;
        handle_pool[0]  = 32'hFFFF_FFFF;
        handle_pool[1]  = 32'h0000_0001;
        for (int i = 2; i < 8; i++) handle_pool[i] = $urandom | 32'h1;
        phase_bases[0] = '1;
        phase_bases[1] = '0;
        phase_bases[2] = BASE_W'($urandom_range(1022, 1));
        phase_bases[3] = '1;
        phase_bases[4] = BASE_W'($urandom_range(1022, 1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_req(FN_LOOKUP, 0, '0, 1'b1, mk_res(ST_BAD, 0, '0, 1'b0, 0));
        directed_req(FN_ALLOC, 0, '0, 1'b1, mk_res(ST_BAD, 0, '0, 1'b0, 0));
        directed_req(FN_FIND, 0, '0, 1'b1, mk_res(ST_BAD, 0, '0, 1'b0, 0));
        directed_req(FN_ALLOC, 0, 32'hFFFF_FFFF, 1'b1, mk_res(ST_OK, 0, '0, 1'b0, 1));
        directed_req(FN_ALLOC, 0, 32'h0000_0001, 1'b1, mk_res(ST_OK, 1, '0, 1'b0, 2));
        directed_req(FN_ALLOC, 0, 32'hFFFF_FFFF, 1'b1, mk_res(ST_OK, 2, '0, 1'b0, 3));
        directed_req(FN_FIND, 0, 32'hFFFF_FFFF, 1'b1, mk_res(ST_OK, 0, '0, 1'b0, 3));
        directed_req(FN_LOOKUP, 1, '0, 1'b1, mk_res(ST_OK, 0, 32'h0000_0001, 1'b0, 3));
        directed_req(FN_FREE, 0, '0, 1'b1, mk_res(ST_OK, 0, 32'hFFFF_FFFF, 1'b1, 2));
        directed_req(FN_FIND, 0, 32'hFFFF_FFFF, 1'b1, mk_res(ST_OK, 2, '0, 1'b0, 2));
        directed_req(FN_FREE, 0, '0, 1'b1, mk_res(ST_BAD, 0, '0, 1'b0, 2));
        directed_req(FN_FREE, 2047, '1, 1'b1, mk_res(ST_BAD, 0, '0, 1'b0, 2));
        directed_req(FN_LOOKUP, SLOTS, '0, 1'b1, mk_res(ST_BAD, 0, '0, 1'b0, 2));
        directed_req(FN_BAD_LO, 2047, '1, 1'b1, mk_res(ST_BAD, 0, '0, 1'b0, 2));
        directed_req(FN_BAD_HI, 0, '0, 1'b1, mk_res(ST_BAD, 0, '0, 1'b0, 2));
        directed_req(FN_ALLOC, 2047, 32'h8000_0000, 1'b0, t_res'(0));
        directed_req(FN_FIND, 0, 32'h1234_5678, 1'b0, t_res'(0));
        directed_req(FN_LOOKUP, 3, '0, 1'b0, t_res'(0));
        directed_req(FN_CLEAR, 0, '0, 1'b1, mk_res(ST_OK, 0, '0, 1'b0, 0));
        directed_req(FN_LOOKUP, 1, '0, 1'b1, mk_res(ST_BAD, 0, '0, 1'b0, 0));
        directed_req(FN_ALLOC, 0, 32'hA5A5_A5A5, 1'b1, mk_res(ST_OK, 0, '0, 1'b0, 1));
        directed_req(FN_FREE, 0, '0, 1'b1, mk_res(ST_OK, 0, 32'hA5A5_A5A5, 1'b1, 0));
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].op, directed_rows[i].fd, directed_rows[i].h,
                         directed_rows[i].typed, directed_rows[i].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            write_fd_base(phase_bases[p]);
            steady_run = (p == 1);
            if (p == 2) hold_off_asked++;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 3) begin
                    // fill the table past full
                    repeat (SLOTS + 4) begin
                        h = pick_handle();
                        if (h == '0) h = handle_pool[0];
                        send_request(FN_ALLOC, FD_W'($urandom), h, 1'b0, t_res'(0));
                    end
                end
                if (p == 3 && k == PHASE_ITEMS / 2) wait_for_results();
                random_request();
            end
        end

        wait_for_results();
        steady_run = 1'b0;
        repeat (2 * SLOTS + 16) @(posedge i_clk);
        if (mismatch_total == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: next_fit_descriptor_allocator_unit.f
rtl/nfda_pkg.sv
rtl/nfda_req_if.sv
rtl/nfda_rsp_if.sv
rtl/next_fit_descriptor_allocator_unit.sv
bench/tb_top.sv
